>>> hw/rtl/hprp_pkg.sv
`default_nettype none
package hprp_pkg;

  localparam int HeaderBytesDef = 31;

  localparam logic [2:0] K_HEADER  = 3'd0;
  localparam logic [2:0] K_START   = 3'd1;
  localparam logic [2:0] K_FIELD   = 3'd2;
  localparam logic [2:0] K_STRBYTE = 3'd3;
  localparam logic [2:0] K_END     = 3'd4;
  localparam logic [2:0] K_ERROR   = 3'd5;

  localparam logic [2:0] E_NO_NUL   = 3'd1;
  localparam logic [2:0] E_SHORT    = 3'd2;
  localparam logic [2:0] E_TRUNC    = 3'd3;
  localparam logic [2:0] E_BAD_ID   = 3'd4;

  localparam logic [7:0] TAG_UTF8    = 8'h01;
  localparam logic [7:0] TAG_LOAD    = 8'h02;
  localparam logic [7:0] TAG_UNLOAD  = 8'h03;
  localparam logic [7:0] TAG_FRAME   = 8'h04;
  localparam logic [7:0] TAG_SUMMARY = 8'h07;
  localparam logic [7:0] TAG_START   = 8'h0A;
  localparam logic [7:0] TAG_END     = 8'h0B;
  localparam logic [7:0] TAG_CONTROL = 8'h0E;
  localparam logic [7:0] TAG_DUMPEND = 8'h2C;

  localparam logic [3:0] ID_CODE = 4'd9;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tag;
    logic [2:0]  fnum;
    logic [63:0] value;
    logic [31:0] rtime;
    logic [31:0] plen;
    logic        ok;
    logic [2:0]  err;
  } result_t;

  // Byte size code of one layout slot; ID_CODE stands for the id size, 0 ends it.
  function automatic logic [3:0] layout_slot(input logic [7:0] tag, input logic [2:0] pos);
    logic [3:0] s;
    s = 4'd0;
    case (tag)
      TAG_UTF8:    s = (pos == 3'd0) ? ID_CODE : 4'd0;
      TAG_LOAD: begin
        case (pos)
          3'd0, 3'd2: s = 4'd4;
          3'd1, 3'd3: s = ID_CODE;
          default:    s = 4'd0;
        endcase
      end
      TAG_UNLOAD, TAG_END: s = (pos == 3'd0) ? 4'd4 : 4'd0;
      TAG_FRAME: begin
        case (pos)
          3'd0, 3'd1, 3'd2, 3'd3: s = ID_CODE;
          3'd4, 3'd5:             s = 4'd4;
          default:                s = 4'd0;
        endcase
      end
      TAG_SUMMARY: begin
        case (pos)
          3'd0, 3'd1: s = 4'd4;
          3'd2, 3'd3: s = 4'd8;
          default:    s = 4'd0;
        endcase
      end
      TAG_START: begin
        case (pos)
          3'd0, 3'd2:             s = 4'd4;
          3'd1, 3'd3, 3'd4, 3'd5: s = ID_CODE;
          default:                s = 4'd0;
        endcase
      end
      TAG_CONTROL: begin
        case (pos)
          3'd0:    s = 4'd4;
          3'd1:    s = 4'd2;
          default: s = 4'd0;
        endcase
      end
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hprp_out_buf.sv
`default_nettype none
module hprp_out_buf
  import hprp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire logic    two,
  input  var  result_t r0,
  input  var  result_t r1,
  output logic         can_take,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_r,
  output logic         out_last
);

  // Four-entry queue; a push of up to two words is allowed while two slots are free.
  result_t     q_r [4];
  logic        l_r [4];
  logic [1:0]  rd_r, rd_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  wr;
  logic        pop;
  logic [2:0]  npush;

  assign pop       = (cnt_r != 3'd0) && !out_stall;
  assign npush     = push ? (two ? 3'd2 : 3'd1) : 3'd0;
  assign can_take  = (cnt_r - (pop ? 3'd1 : 3'd0)) <= 3'd2;
  assign wr        = rd_r + cnt_r[1:0];
  assign out_valid = cnt_r != 3'd0;
  assign out_r     = q_r[rd_r];
  assign out_last  = l_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r + (pop ? 2'd1 : 2'd0);
    cnt_nxt = cnt_r - (pop ? 3'd1 : 3'd0) + npush;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wr] <= r0;
      l_r[wr] <= !two;
      if (two) begin
        q_r[wr + 2'd1] <= r1;
        l_r[wr + 2'd1] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/heap_profile_record_parser_core.sv
// Result path: an accepted byte passes one input stage, then a four-word output
// queue, before its results appear on out_.
// Throughput: one byte per cycle while the result side keeps up; each byte
// gives zero to two words, and the queue sets the back pressure.
// Reset (rst_n low, synchronous) returns the parser to the file header.
`default_nettype none
module heap_profile_record_parser_core
  import hprp_pkg::*;
#(
  parameter int HEADER_BYTES = HeaderBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_stream,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_result_kind,
  output logic [7:0]       out_record_tag,
  output logic [2:0]       out_field_number,
  output logic [63:0]      out_field_value,
  output logic [31:0]      out_record_time,
  output logic [31:0]      out_payload_length,
  output logic             out_length_ok,
  output logic [2:0]       out_error_code,
  output logic             out_last_of_run
);

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_TAG     = 5'b00010,
    PH_RECHDR  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_HALT    = 5'b10000
  } phase_t;

  localparam logic [5:0] NUL_NONE = 6'd63;
  localparam logic [5:0] NUL_LIMIT = 6'(HEADER_BYTES - 13);
  localparam logic [5:0] HDR_LAST = 6'(HEADER_BYTES);

  phase_t      ph_r, ph_nxt;
  logic [5:0]  hpos_r, hpos_nxt;
  logic [5:0]  nul_r, nul_nxt;
  logic [3:0]  idb_r, idb_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [3:0]  rhc_r, rhc_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] left_r, left_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [3:0]  fbc_r, fbc_nxt;
  logic [2:0]  fpos_r, fpos_nxt;

  logic        in_v_r;
  logic [7:0]  b_r;
  logic        last_r;

  logic        can_take, take, push, two;
  result_t     r0, r1, qo;
  logic [1:0]  n;

  logic [5:0]  off;
  logic [63:0] shb;
  logic [31:0] lenb;
  logic [34:0] id2, id4;
  logic        ok;
  logic [3:0]  slot, sz;
  logic [3:0]  fbc_inc;
  logic [31:0] left_dec;

  // The input stage holds one byte; it is consumed when the queue has room.
  assign take     = in_v_r && can_take;
  assign in_stall = in_v_r && !can_take;
  assign push     = take && (n != 2'd0);
  assign two      = n == 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (take) begin
      in_v_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      b_r    <= in_data_byte;
      last_r <= in_end_of_stream;
    end
  end

  assign off  = hpos_r - nul_r;
  assign shb  = {sh_r[55:0], b_r};
  assign lenb = {left_r[23:0], b_r};
  assign id2  = 35'd8 + {30'd0, idb_r, 1'b0};
  assign id4  = 35'd8 + {29'd0, idb_r, 2'b0};
  assign slot = layout_slot(tag_r, fpos_r);
  assign sz   = (slot == ID_CODE) ? idb_r : slot;
  assign fbc_inc  = fbc_r + 4'd1;
  assign left_dec = left_r - 32'd1;

  always_comb begin
    case (tag_r)
      TAG_UTF8:    ok = lenb >= {28'd0, idb_r};
      TAG_LOAD:    ok = {3'd0, lenb} >= id2;
      TAG_UNLOAD:  ok = lenb == 32'd4;
      TAG_FRAME:   ok = {3'd0, lenb} == id4;
      TAG_SUMMARY: ok = lenb == 32'd24;
      TAG_START:   ok = {3'd0, lenb} == id4;
      TAG_END:     ok = lenb == 32'd4;
      TAG_CONTROL: ok = lenb == 32'd6;
      TAG_DUMPEND: ok = lenb == 32'd0;
      default:     ok = 1'b1;
    endcase
  end

  always_comb begin
    result_t base;
    result_t em;
    logic    halt;
    logic    closed;
    base     = '0;
    base.tag = tag_r;
    em       = base;
    halt     = 1'b0;
    closed   = 1'b0;
    n        = 2'd0;
    r0       = base;
    r1       = base;
    ph_nxt   = ph_r;
    hpos_nxt = hpos_r;
    nul_nxt  = nul_r;
    idb_nxt  = idb_r;
    tag_nxt  = tag_r;
    rhc_nxt  = rhc_r;
    time_nxt = time_r;
    left_nxt = left_r;
    sh_nxt   = sh_r;
    fbc_nxt  = fbc_r;
    fpos_nxt = fpos_r;
    case (ph_r)
      PH_HEADER: begin
        if (nul_r == NUL_NONE) begin
          if (b_r == 8'd0) begin
            nul_nxt = hpos_r;
          end else if (hpos_r >= NUL_LIMIT) begin
            em.kind = K_ERROR;
            em.err  = E_NO_NUL;
            halt    = 1'b1;
          end
        end else if (off >= 6'd1 && off <= 6'd12) begin
          sh_nxt = shb;
          if (off == 6'd4) begin
            if (shb == 64'd0 || shb > 64'd8) begin
              em.kind = K_ERROR;
              em.err  = E_BAD_ID;
              halt    = 1'b1;
            end else begin
              idb_nxt  = shb[3:0];
              em.kind  = K_HEADER;
              em.value = shb;
              n        = 2'd1;
              sh_nxt   = '0;
            end
          end else if (off == 6'd12) begin
            em.kind  = K_HEADER;
            em.fnum  = 3'd1;
            em.value = shb;
            n        = 2'd1;
            sh_nxt   = '0;
          end
        end
        if (halt) begin
          n        = 2'd1;
          r0       = em;
          ph_nxt   = PH_HALT;
        end else begin
          if (n != 2'd0) r0 = em;
          hpos_nxt = hpos_r + 6'd1;
          if (hpos_nxt >= HDR_LAST) begin
            ph_nxt = PH_TAG;
            closed = 1'b1;
          end
        end
      end
      PH_TAG: begin
        tag_nxt  = b_r;
        rhc_nxt  = 4'd0;
        time_nxt = '0;
        left_nxt = '0;
        ph_nxt   = PH_RECHDR;
        if (last_r) begin
          r0.tag  = b_r;
          r0.kind = K_ERROR;
          r0.err  = E_TRUNC;
          n       = 2'd1;
          ph_nxt  = PH_HALT;
          halt    = 1'b1;
        end
      end
      PH_RECHDR: begin
        if (rhc_r < 4'd4) time_nxt = {time_r[23:0], b_r};
        else left_nxt = lenb;
        rhc_nxt = rhc_r + 4'd1;
        if (rhc_nxt == 4'd8) begin
          r0.kind  = K_START;
          r0.rtime = time_r;
          r0.plen  = lenb;
          r0.ok    = ok;
          n        = 2'd1;
          fpos_nxt = '0;
          fbc_nxt  = '0;
          sh_nxt   = '0;
          if (tag_r == TAG_LOAD && !ok) begin
            r1.kind = K_ERROR;
            r1.err  = E_SHORT;
            n       = 2'd2;
            ph_nxt  = PH_HALT;
            halt    = 1'b1;
          end else if (lenb == 32'd0) begin
            ph_nxt = PH_TAG;
            closed = 1'b1;
          end else begin
            ph_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        left_nxt = left_dec;
        if (tag_r == TAG_UTF8 && fpos_r >= 3'd1) begin
          r0.kind  = K_STRBYTE;
          r0.fnum  = 3'd1;
          r0.value = {56'd0, b_r};
          n        = 2'd1;
        end else if (sz != 4'd0) begin
          sh_nxt  = shb;
          fbc_nxt = fbc_inc;
          if (fbc_inc >= sz) begin
            r0.kind  = K_FIELD;
            r0.fnum  = fpos_r;
            r0.value = shb;
            n        = 2'd1;
            fpos_nxt = fpos_r + 3'd1;
            fbc_nxt  = '0;
            sh_nxt   = '0;
          end
        end
        if (left_dec == 32'd0) begin
          ph_nxt = PH_TAG;
          closed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (ph_r != PH_HALT && !halt && last_r) begin
      em      = base;
      em.tag  = tag_nxt;
      em.kind = closed ? K_END : K_ERROR;
      em.err  = closed ? 3'd0 : E_TRUNC;
      ph_nxt  = PH_HALT;
      if (n == 2'd0) r0 = em;
      else r1 = em;
      n = n + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_HEADER;
      hpos_r <= '0;
      nul_r  <= NUL_NONE;
      idb_r  <= '0;
      tag_r  <= '0;
      rhc_r  <= '0;
      time_r <= '0;
      left_r <= '0;
      sh_r   <= '0;
      fbc_r  <= '0;
      fpos_r <= '0;
    end else if (take) begin
      ph_r   <= ph_nxt;
      hpos_r <= hpos_nxt;
      nul_r  <= nul_nxt;
      idb_r  <= idb_nxt;
      tag_r  <= tag_nxt;
      rhc_r  <= rhc_nxt;
      time_r <= time_nxt;
      left_r <= left_nxt;
      sh_r   <= sh_nxt;
      fbc_r  <= fbc_nxt;
      fpos_r <= fpos_nxt;
    end
  end

  hprp_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .two       (two),
    .r0        (r0),
    .r1        (r1),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_r     (qo),
    .out_last  (out_last_of_run)
  );

  assign out_result_kind    = qo.kind;
  assign out_record_tag     = qo.tag;
  assign out_field_number   = qo.fnum;
  assign out_field_value    = qo.value;
  assign out_record_time    = qo.rtime;
  assign out_payload_length = qo.plen;
  assign out_length_ok      = qo.ok;
  assign out_error_code     = qo.err;

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import hprp_pkg::*;

  localparam int HB = HeaderBytesDef;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  tag;
    logic [2:0]  fnum;
    logic [63:0] value;
    logic [31:0] rtime;
    logic [31:0] plen;
    logic        ok;
    logic [2:0]  err;
    logic        last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_result_kind;
  logic [7:0]  out_record_tag;
  logic [2:0]  out_field_number;
  logic [63:0] out_field_value;
  logic [31:0] out_record_time;
  logic [31:0] out_payload_length;
  logic        out_length_ok;
  logic [2:0]  out_error_code;
  logic        out_last_of_run;

  heap_profile_record_parser_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_end_of_stream(in_end_of_stream),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_record_tag(out_record_tag),
    .out_field_number(out_field_number), .out_field_value(out_field_value),
    .out_record_time(out_record_time), .out_payload_length(out_payload_length),
    .out_length_ok(out_length_ok), .out_error_code(out_error_code),
    .out_last_of_run(out_last_of_run)
  );

  always #10 clk = ~clk;

  typedef enum logic [2:0] {
    P_HEADER, P_TAG, P_RECHDR, P_PAYLOAD, P_HALT
  } phase_t;

  localparam logic [5:0] NUL_NONE = 6'd63;

  phase_t      ph;
  logic [5:0]  hdr_pos;
  logic [5:0]  nul_at;
  logic [3:0]  id_size;
  logic [7:0]  cur_tag;
  logic [3:0]  rec_hdr_cnt;
  logic [31:0] rec_time;
  logic [31:0] left_bytes;
  logic [63:0] acc;
  logic [3:0]  acc_cnt;
  logic [2:0]  fld_pos;

  word_t expected_words[$];
  int    error_count = 0;
  int    bytes_sent = 0;
  int    burst_left = 0;
  logic  long_hold = 1'b0;
  int    stall_run = 0;
  int    stall_mode = 0;

  function automatic int slot_bytes(logic [7:0] t, logic [2:0] p);
    int s;
    s = 0;
    case (t)
      TAG_UTF8:    if (p == 0) s = -1;
      TAG_LOAD:    if (p < 4) s = (p[0]) ? -1 : 4;
      TAG_UNLOAD,
      TAG_END:     if (p == 0) s = 4;
      TAG_FRAME:   if (p < 4) s = -1; else if (p < 6) s = 4;
      TAG_SUMMARY: if (p < 2) s = 4; else if (p < 4) s = 8;
      TAG_START:   if (p == 0 || p == 2) s = 4; else if (p < 6) s = -1;
      TAG_CONTROL: if (p == 0) s = 4; else if (p == 1) s = 2;
      default:     s = 0;
    endcase
    if (s < 0) s = id_size;
    return s;
  endfunction

  function automatic logic fits_layout(logic [7:0] t, logic [31:0] len);
    longint unsigned n, id;
    n = len;
    id = id_size;
    case (t)
      TAG_UTF8:    return n >= id;
      TAG_LOAD:    return n >= 8 + 2 * id;
      TAG_UNLOAD,
      TAG_END:     return n == 4;
      TAG_FRAME,
      TAG_START:   return n == 8 + 4 * id;
      TAG_SUMMARY: return n == 24;
      TAG_CONTROL: return n == 6;
      TAG_DUMPEND: return n == 0;
      default:     return 1'b1;
    endcase
  endfunction

  task automatic push_word(input logic [2:0] k, input logic [2:0] fn, input logic [63:0] v,
                           input logic [31:0] rt, input logic [31:0] pl, input logic ok,
                           input logic [2:0] e);
    word_t w;
    w.kind = k; w.tag = cur_tag; w.fnum = fn; w.value = v; w.rtime = rt;
    w.plen = pl; w.ok = ok; w.err = e; w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic halt_with(input logic [2:0] e);
    push_word(K_ERROR, 3'd0, 64'd0, 32'd0, 32'd0, 1'b0, e);
    ph = P_HALT;
  endtask

  task automatic stream_end();
    push_word(K_END, 3'd0, 64'd0, 32'd0, 32'd0, 1'b0, 3'd0);
    ph = P_HALT;
  endtask

  task automatic close_or_truncate(input logic closes, input logic last);
    if (closes) begin
      ph = P_TAG;
      if (last) stream_end();
    end else if (last) begin
      halt_with(E_TRUNC);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    int n0;
    logic [5:0] off;
    logic ok;
    int sz;
    n0 = expected_words.size();
    case (ph)
      P_HEADER: begin
        if (nul_at == NUL_NONE && b != 0 && hdr_pos >= HB - 13) begin
          halt_with(E_NO_NUL);
        end else begin
          if (nul_at == NUL_NONE) begin
            if (b == 0) nul_at = hdr_pos;
          end else begin
            off = hdr_pos - nul_at;
            if (off >= 1 && off <= 12) begin
              acc = (acc << 8) | b;
              if (off == 4) begin
                if (acc == 0 || acc > 8) begin
                  halt_with(E_BAD_ID);
                end else begin
                  id_size = acc[3:0];
                  push_word(K_HEADER, 3'd0, acc, 32'd0, 32'd0, 1'b0, 3'd0);
                  acc = 0;
                end
              end else if (off == 12) begin
                push_word(K_HEADER, 3'd1, acc, 32'd0, 32'd0, 1'b0, 3'd0);
                acc = 0;
              end
            end
          end
          if (ph != P_HALT) begin
            hdr_pos = hdr_pos + 6'd1;
            if (hdr_pos >= HB) begin
              ph = P_TAG;
              if (last) stream_end();
            end else if (last) begin
              halt_with(E_TRUNC);
            end
          end
        end
      end
      P_TAG: begin
        cur_tag = b;
        rec_hdr_cnt = 0;
        rec_time = 0;
        left_bytes = 0;
        ph = P_RECHDR;
        if (last) halt_with(E_TRUNC);
      end
      P_RECHDR: begin
        if (rec_hdr_cnt < 4) rec_time = (rec_time << 8) | b;
        else left_bytes = (left_bytes << 8) | b;
        rec_hdr_cnt = rec_hdr_cnt + 4'd1;
        if (rec_hdr_cnt < 8) begin
          if (last) halt_with(E_TRUNC);
        end else begin
          ok = fits_layout(cur_tag, left_bytes);
          push_word(K_START, 3'd0, 64'd0, rec_time, left_bytes, ok, 3'd0);
          fld_pos = 0;
          acc_cnt = 0;
          acc = 0;
          if (cur_tag == TAG_LOAD && !ok) begin
            halt_with(E_SHORT);
          end else if (left_bytes == 0) begin
            close_or_truncate(1'b1, last);
          end else begin
            ph = P_PAYLOAD;
            if (last) halt_with(E_TRUNC);
          end
        end
      end
      P_PAYLOAD: begin
        left_bytes = left_bytes - 32'd1;
        if (cur_tag == TAG_UTF8 && fld_pos >= 1) begin
          push_word(K_STRBYTE, 3'd1, {56'd0, b}, 32'd0, 32'd0, 1'b0, 3'd0);
        end else begin
          sz = slot_bytes(cur_tag, fld_pos);
          if (sz != 0) begin
            acc = (acc << 8) | b;
            acc_cnt = acc_cnt + 4'd1;
            if (acc_cnt >= sz) begin
              push_word(K_FIELD, fld_pos, acc, 32'd0, 32'd0, 1'b0, 3'd0);
              fld_pos = fld_pos + 3'd1;
              acc_cnt = 0;
              acc = 0;
            end
          end
        end
        close_or_truncate(left_bytes == 0, last);
      end
      default: ;
    endcase
    if (expected_words.size() > n0)
      expected_words[expected_words.size() - 1].last = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data_byte = b;
    in_end_of_stream = last;
    do @(posedge clk); while (in_stall);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word kind", {61'd0, out_result_kind}, 64'd0);
      end else begin
        w = expected_words.pop_front();
        if (out_result_kind !== w.kind) report_mismatch("kind", out_result_kind, w.kind);
        if (out_record_tag !== w.tag) report_mismatch("tag", out_record_tag, w.tag);
        if (out_field_number !== w.fnum) report_mismatch("field", out_field_number, w.fnum);
        if (out_field_value !== w.value) report_mismatch("value", out_field_value, w.value);
        if (out_record_time !== w.rtime) report_mismatch("time", out_record_time, w.rtime);
        if (out_payload_length !== w.plen)
          report_mismatch("length", out_payload_length, w.plen);
        if (out_length_ok !== w.ok) report_mismatch("length_ok", out_length_ok, w.ok);
        if (out_error_code !== w.err) report_mismatch("error", out_error_code, w.err);
        if (out_last_of_run !== w.last) report_mismatch("last", out_last_of_run, w.last);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(1, 60);
    end
    stall_run--;
    if (long_hold) out_stall <= 1'b1;
    else case (stall_mode)
      0, 1: out_stall <= 1'b0;
      2:    out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_u4(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) send_byte(v[8*i +: 8], 1'b0);
  endtask

  // Sends one record whose payload is len bytes of random content.
  task automatic send_record(input logic [7:0] t, input logic [31:0] len, input logic eos);
    send_byte(t, 1'b0);
    send_u4({16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))});
    for (int i = 3; i >= 0; i--)
      send_byte(len[8*i +: 8], eos && len == 0 && i == 0);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), eos && i == len - 1);
  endtask

  function automatic logic [31:0] proper_length(input logic [7:0] t);
    case (t)
      TAG_UTF8:    return id_size + $urandom_range(0, 12);
      TAG_LOAD:    return 8 + 2 * id_size + (($urandom_range(0, 3) == 0) ? 2 : 0);
      TAG_UNLOAD,
      TAG_END:     return 4;
      TAG_FRAME,
      TAG_START:   return 8 + 4 * id_size;
      TAG_SUMMARY: return 24;
      TAG_CONTROL: return 6;
      TAG_DUMPEND: return 0;
      default:     return $urandom_range(0, 10);
    endcase
  endfunction

  function automatic logic [7:0] random_tag();
    case ($urandom_range(0, 10))
      0: return TAG_UTF8;
      1: return TAG_LOAD;
      2: return TAG_UNLOAD;
      3: return TAG_FRAME;
      4: return TAG_SUMMARY;
      5: return TAG_START;
      6: return TAG_END;
      7: return TAG_CONTROL;
      8: return TAG_DUMPEND;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_record();
    logic [7:0] t;
    logic [31:0] len;
    t = random_tag();
    len = proper_length(t);
    if (t != TAG_LOAD && $urandom_range(0, 4) == 0) len = $urandom_range(0, 30);
    send_record(t, len, 1'b0);
  endtask

  task automatic test_header();
    int nul_pos;
    nul_pos = $urandom_range(0, HB - 13);
    for (int p = 0; p < HB; p++) begin
      if (p < nul_pos) send_byte(8'($urandom_range(1, 255)), 1'b0);
      else if (p == nul_pos) send_byte(8'h00, 1'b0);
      else if (p == nul_pos + 4) send_byte(8'($urandom_range(1, 8)), 1'b0);
      else if (p < nul_pos + 4) send_byte(8'h00, 1'b0);
      else send_byte(pick_byte(), 1'b0);
    end
  endtask

  task automatic test_each_tag();
    send_record(TAG_UTF8, 32'(id_size), 1'b0);
    send_record(TAG_UTF8, id_size + 5, 1'b0);
    send_record(TAG_LOAD, 8 + 2 * id_size, 1'b0);
    send_record(TAG_UNLOAD, 4, 1'b0);
    send_record(TAG_FRAME, 8 + 4 * id_size, 1'b0);
    send_record(TAG_SUMMARY, 24, 1'b0);
    send_record(TAG_START, 8 + 4 * id_size, 1'b0);
    send_record(TAG_END, 4, 1'b0);
    send_record(TAG_CONTROL, 6, 1'b0);
    send_record(TAG_DUMPEND, 0, 1'b0);
    send_record(8'hFF, 3, 1'b0);
    send_record(8'h00, 0, 1'b0);
  endtask

  task automatic test_length_mismatch();
    send_record(TAG_UNLOAD, 2, 1'b0);
    send_record(TAG_SUMMARY, 30, 1'b0);
    send_record(TAG_CONTROL, 0, 1'b0);
    send_record(TAG_DUMPEND, 3, 1'b0);
    send_record(TAG_LOAD, 8 + 2 * id_size + 5, 1'b0);
  endtask

  task automatic test_random_records();
    while (bytes_sent < 1500) send_random_record();
  endtask

  task automatic test_long_hold();
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      repeat (6) send_random_record();
    join
  endtask

  task automatic test_drain_pause();
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_words.size() == 0);
    repeat (30) send_random_record();
  endtask

  task automatic test_stream_end();
    while (bytes_sent < 1750) send_random_record();
    case ($urandom_range(0, 2))
      0: send_record(random_tag(), proper_length(TAG_UNLOAD), 1'b1);
      1: send_record(TAG_LOAD, 8 + 2 * id_size - 1, 1'b0);
      default: begin
        send_byte(TAG_FRAME, 1'b0);
        send_u4(32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1);
      end
    endcase
    for (int i = 0; i < 8; i++) send_byte(pick_byte(), i[0]);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  initial begin
    ph = P_HEADER; hdr_pos = 0; nul_at = NUL_NONE; id_size = 0; cur_tag = 0;
    rec_hdr_cnt = 0; rec_time = 0; left_bytes = 0; acc = 0; acc_cnt = 0; fld_pos = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_header();
    test_each_tag();
    test_length_mismatch();
    test_long_hold();
    test_drain_pause();
    test_random_records();
    test_stream_end();
    wait (expected_words.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/hprp_pkg.sv
hw/rtl/hprp_out_buf.sv
hw/rtl/heap_profile_record_parser_core.sv
tb/sv/tb_top.sv
